// ===== rtl/core/wsfd_pkg.sv =====
`timescale 1ns / 1ps

package wsfd_pkg;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [7:0] CRC_POLY    = 8'h31;
	localparam logic [7:0] FAMILY_CODE = 8'h24;

	localparam int STORE_DEPTH = 14;
	localparam int STORE_IDX_W = 4;
	localparam int POS_W       = 5;

	localparam logic [POS_W-1:0] POS_IDLE  = 5'd0;
	localparam logic [POS_W-1:0] POS_FIRST = 5'd1;
	localparam logic [POS_W-1:0] POS_LAST  = 5'd15;
	localparam logic [POS_W-1:0] POS_DONE  = 5'd16;

	localparam logic [11:0] TEMP_OFFSET = 12'd400;

	// wind, gust and rain factors for each model
	localparam logic [9:0]  WIND_F_WH24  = 10'd560;
	localparam logic [9:0]  WIND_F_WH65B = 10'd255;
	localparam logic [12:0] GUST_F_WH24  = 13'd4480;
	localparam logic [12:0] GUST_F_WH65B = 13'd2040;
	localparam logic [8:0]  RAIN_F_WH24  = 9'd300;
	localparam logic [8:0]  RAIN_F_WH65B = 9'd254;

	typedef enum logic [0:0] {
		MODEL_BASE = 1'b0,
		MODEL_ALT  = 1'b1
	} model_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_FAMILY = 2'd1,
		STATUS_BAD_CRC    = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_MODEL_SELECT = 1'b0
	} reg_idx_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] rem, input logic [7:0] data);
		logic [7:0] v;
		v = rem ^ data;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ===== rtl/core/wsfd_if.sv =====
`timescale 1ns / 1ps

interface wsfd_in_if;
	import wsfd_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface wsfd_out_if;
	import wsfd_pkg::*;

	logic               valid;
	logic               ready;
	logic               frame_valid;
	logic [1:0]         status;
	logic [7:0]         sensor_id;
	logic               batt_low;
	logic signed [11:0] temperature_tenths;
	logic [7:0]         humidity;
	logic [8:0]         wind_direction;
	logic [18:0]        wind_speed_q;
	logic [20:0]        gust_speed_q;
	logic [24:0]        rain_hundredths;
	logic [15:0]        uv_raw;
	logic [23:0]        light_level;

	modport source (
		output valid, input ready,
		output frame_valid, output status, output sensor_id, output batt_low,
		output temperature_tenths, output humidity, output wind_direction,
		output wind_speed_q, output gust_speed_q, output rain_hundredths,
		output uv_raw, output light_level
	);
	modport sink (
		input valid, output ready,
		input frame_valid, input status, input sensor_id, input batt_low,
		input temperature_tenths, input humidity, input wind_direction,
		input wind_speed_q, input gust_speed_q, input rain_hundredths,
		input uv_raw, input light_level
	);
endinterface

// ===== rtl/core/weather_sensor_frame_decoder_unit.sv =====
// channel   | dir | transfer                          | payload
// ----------+-----+-----------------------------------+---------------------------------
// frame     | in  | valid & ready                     | data_byte, frame_start
// result    | out | valid & ready                     | frame_valid, status, sensor fields
// apb       | in  | psel & penable & pwrite & pready  | model_select at byte address 0
//
// one byte is taken per cycle while frame.ready is high; crc step and byte store happen at the transfer
// the result register loads at the transfer of byte 15 and offers it the next cycle
// frame.ready drops only while a result is held and result.ready is low
// reset clears position, crc, family flag, model select and result valid
`timescale 1ns / 1ps

module weather_sensor_frame_decoder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	wsfd_in_if.sink                      frame,
	wsfd_out_if.source                   result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wsfd_pkg::PADDR_W-1:0] paddr,
	input  logic [wsfd_pkg::PDATA_W-1:0] pwdata,
	output logic [wsfd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import wsfd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       crc_q;
	logic             fam_q;
	model_t           model_q;
	logic [7:0]       store_q [STORE_DEPTH];
	logic             res_valid_q;

	logic             accept;
	logic             last_byte;
	logic             reg_hit;
	logic [STORE_IDX_W-1:0] store_idx;

	logic [7:0]  b3;
	logic [10:0] temp_raw;
	logic [8:0]  wind_raw;
	logic [9:0]  wind_f;
	logic [12:0] gust_f;
	logic [8:0]  rain_f;
	status_t     status_d;
	logic        ok_d;

	// config port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_MODEL_SELECT);
	assign prdata  = reg_hit ? {{(PDATA_W-1){1'b0}}, model_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= MODEL_BASE;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			model_q <= model_t'(pwdata[0]);
		end
	end

	// input side
	assign frame.ready = !res_valid_q || result.ready;
	assign accept      = frame.valid && frame.ready;
	assign last_byte   = accept && !frame.frame_start && (pos_q == POS_LAST);
	assign store_idx   = STORE_IDX_W'(pos_q - POS_FIRST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			crc_q <= '0;
			fam_q <= 1'b0;
		end else if (accept) begin
			if (frame.frame_start) begin
				fam_q <= (frame.data_byte == FAMILY_CODE);
				crc_q <= crc8_update(8'h00, frame.data_byte);
				pos_q <= POS_FIRST;
			end else if (pos_q != POS_IDLE && pos_q < POS_LAST) begin
				crc_q <= crc8_update(crc_q, frame.data_byte);
				pos_q <= pos_q + POS_FIRST;
			end else if (pos_q == POS_LAST) begin
				pos_q <= POS_DONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !frame.frame_start && pos_q != POS_IDLE && pos_q < POS_LAST) begin
			store_q[store_idx] <= frame.data_byte;
		end
	end

	// field unpacking
	assign b3       = store_q[2];
	assign temp_raw = {b3[2:0], store_q[3]};
	assign wind_raw = {b3[4], store_q[5]};
	assign wind_f   = (model_q == MODEL_ALT) ? WIND_F_WH65B : WIND_F_WH24;
	assign gust_f   = (model_q == MODEL_ALT) ? GUST_F_WH65B : GUST_F_WH24;
	assign rain_f   = (model_q == MODEL_ALT) ? RAIN_F_WH65B : RAIN_F_WH24;

	always_comb begin
		if (!fam_q) begin
			status_d = STATUS_BAD_FAMILY;
		end else if (crc_q != frame.data_byte) begin
			status_d = STATUS_BAD_CRC;
		end else begin
			status_d = STATUS_OK;
		end
		ok_d = (status_d == STATUS_OK);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (last_byte) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_byte) begin
			result.frame_valid <= ok_d;
			result.status      <= status_d;
			if (ok_d) begin
				result.sensor_id          <= store_q[0];
				result.batt_low           <= b3[3];
				result.temperature_tenths <= signed'({1'b0, temp_raw} - TEMP_OFFSET);
				result.humidity           <= store_q[4];
				result.wind_direction     <= {b3[7], store_q[1]};
				result.wind_speed_q       <= 19'(19'(wind_raw) * 19'(wind_f));
				result.gust_speed_q       <= 21'(21'(store_q[6]) * 21'(gust_f));
				result.rain_hundredths    <= 25'(25'({store_q[7], store_q[8]}) * 25'(rain_f));
				result.uv_raw             <= {store_q[9], store_q[10]};
				result.light_level        <= {store_q[11], store_q[12], store_q[13]};
			end else begin
				result.sensor_id          <= '0;
				result.batt_low           <= 1'b0;
				result.temperature_tenths <= '0;
				result.humidity           <= '0;
				result.wind_direction     <= '0;
				result.wind_speed_q       <= '0;
				result.gust_speed_q       <= '0;
				result.rain_hundredths    <= '0;
				result.uv_raw             <= '0;
				result.light_level        <= '0;
			end
		end
	end

	assign result.valid = res_valid_q;

endmodule

// ===== sim/weather_sensor_frame_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module weather_sensor_frame_decoder_unit_tb;
	import wsfd_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam logic [PADDR_W-1:0] MODEL_ADDR = PADDR_W'(4 * REG_MODEL_SELECT);
	localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);
	localparam logic [11:0] TEMP_BIAS = 12'd400;
	localparam int WH24_WIND_Q  = 560;
	localparam int WH24_GUST_Q  = 4480;
	localparam int WH24_RAIN_H  = 300;
	localparam int WH65B_WIND_Q = 255;
	localparam int WH65B_GUST_Q = 2040;
	localparam int WH65B_RAIN_H = 254;

	typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

	typedef struct packed {
		logic       start;
		logic [7:0] data;
	} byte_item_t;

	typedef struct packed {
		logic               frame_valid;
		status_t            status;
		logic [7:0]         sensor_id;
		logic               batt_low;
		logic signed [11:0] temperature_tenths;
		logic [7:0]         humidity;
		logic [8:0]         wind_direction;
		logic [18:0]        wind_speed_q;
		logic [20:0]        gust_speed_q;
		logic [24:0]        rain_hundredths;
		logic [15:0]        uv_raw;
		logic [23:0]        light_level;
	} weather_rec_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	wsfd_in_if  fin ();
	wsfd_out_if fout ();

	weather_sensor_frame_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(fin),
		.result(fout),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	byte_item_t   byte_queue[$];
	weather_rec_t readings_expected[$];
	int           bytes_queued = 0;
	int           mismatches = 0;
	int           cycle_count = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	bit           byte_taken = 1'b0;

	// decoder shadow state
	model_t     cur_model;
	logic [4:0] byte_pos;
	logic [7:0] crc_acc;
	logic       fam_seen;
	logic [7:0] body_bytes [14];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] rem, input logic [7:0] d);
		logic [7:0] r;
		logic       fb;
		r = rem;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ d[i];
			r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic st);
		weather_rec_t rec;
		logic [7:0]   b3;
		logic [8:0]   wraw;
		int           wind_f;
		int           gust_f;
		int           rain_f;
		if (st) begin
			fam_seen = (b == FAMILY_CODE);
			crc_acc = crc8_step(8'h00, b);
			byte_pos = POS_FIRST;
		end else if (byte_pos == POS_IDLE || byte_pos > POS_LAST) begin
			byte_pos = byte_pos;
		end else if (byte_pos < POS_LAST) begin
			body_bytes[byte_pos - 5'd1] = b;
			crc_acc = crc8_step(crc_acc, b);
			byte_pos = byte_pos + 5'd1;
		end else begin
			byte_pos = POS_DONE;
			rec = '0;
			if (!fam_seen) begin
				rec.status = STATUS_BAD_FAMILY;
			end else if (crc_acc != b) begin
				rec.status = STATUS_BAD_CRC;
			end else begin
				b3 = body_bytes[2];
				wraw = {b3[4], body_bytes[5]};
				if (cur_model == MODEL_ALT) begin
					wind_f = WH65B_WIND_Q;
					gust_f = WH65B_GUST_Q;
					rain_f = WH65B_RAIN_H;
				end else begin
					wind_f = WH24_WIND_Q;
					gust_f = WH24_GUST_Q;
					rain_f = WH24_RAIN_H;
				end
				rec.frame_valid = 1'b1;
				rec.status = STATUS_OK;
				rec.sensor_id = body_bytes[0];
				rec.batt_low = b3[3];
				rec.temperature_tenths = {b3[2:0], body_bytes[3]} - TEMP_BIAS;
				rec.humidity = body_bytes[4];
				rec.wind_direction = {b3[7], body_bytes[1]};
				rec.wind_speed_q = wraw * wind_f;
				rec.gust_speed_q = body_bytes[6] * gust_f;
				rec.rain_hundredths = {body_bytes[7], body_bytes[8]} * rain_f;
				rec.uv_raw = {body_bytes[9], body_bytes[10]};
				rec.light_level = {body_bytes[11], body_bytes[12], body_bytes[13]};
			end
			readings_expected.push_back(rec);
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		weather_rec_t want;
		byte_taken = fin.valid && fin.ready;
		if (byte_taken) begin
			predict_byte(fin.data_byte, fin.frame_start);
		end
		if (fout.valid && fout.ready) begin
			if (readings_expected.size() == 0) begin
				$display("%0t ns result expected none actual status %0d", $time, fout.status);
				mismatches++;
			end else begin
				want = readings_expected.pop_front();
				compare_field("frame_valid", want.frame_valid, fout.frame_valid);
				compare_field("status", want.status, fout.status);
				compare_field("sensor_id", want.sensor_id, fout.sensor_id);
				compare_field("batt_low", want.batt_low, fout.batt_low);
				compare_field("temperature_tenths", want.temperature_tenths,
					fout.temperature_tenths);
				compare_field("humidity", want.humidity, fout.humidity);
				compare_field("wind_direction", want.wind_direction, fout.wind_direction);
				compare_field("wind_speed_q", want.wind_speed_q, fout.wind_speed_q);
				compare_field("gust_speed_q", want.gust_speed_q, fout.gust_speed_q);
				compare_field("rain_hundredths", want.rain_hundredths, fout.rain_hundredths);
				compare_field("uv_raw", want.uv_raw, fout.uv_raw);
				compare_field("light_level", want.light_level, fout.light_level);
			end
		end
	end

	always @(negedge clk) begin : feeder
		byte_item_t item;
		if (!arst_n) begin
			fin.valid <= 1'b0;
		end else if (!fin.valid || byte_taken) begin
			if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				item = byte_queue.pop_front();
				fin.valid <= 1'b1;
				fin.data_byte <= item.data;
				fin.frame_start <= item.start;
			end else begin
				fin.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		fout.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic void push_byte(input logic [7:0] d, input logic st);
		byte_item_t item;
		item.start = st;
		item.data = d;
		byte_queue.push_back(item);
		bytes_queued++;
	endfunction

	// len below 16 leaves a cut frame that the next start byte drops
	function automatic void queue_frame(input logic [7:0] fam, input fill_t fill,
			input bit bad_crc, input int len);
		logic [7:0] fb [16];
		logic [7:0] crc;
		fb[0] = fam;
		for (int i = 1; i < 15; i++) begin
			case (fill)
				FILL_ZEROS: fb[i] = 8'h00;
				FILL_ONES:  fb[i] = 8'hFF;
				default:    fb[i] = 8'($urandom_range(0, 255));
			endcase
		end
		crc = 8'h00;
		for (int i = 0; i < 15; i++) begin
			crc = crc8_step(crc, fb[i]);
		end
		fb[15] = bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc;
		for (int i = 0; i < len; i++) begin
			push_byte(fb[i], i == 0);
		end
	endfunction

	function automatic logic [7:0] wrong_family();
		logic [7:0] f;
		f = 8'($urandom_range(0, 255));
		if (f == FAMILY_CODE) begin
			f = f ^ 8'($urandom_range(1, 255));
		end
		return f;
	endfunction

	function automatic void queue_random(input int n);
		int    base;
		int    pick;
		int    strays;
		fill_t fill;
		base = bytes_queued;
		while (bytes_queued - base < n) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 19))
				0:       fill = FILL_ZEROS;
				1:       fill = FILL_ONES;
				default: fill = FILL_RANDOM;
			endcase
			if (pick < 60) begin
				queue_frame(FAMILY_CODE, fill, 1'b0, 16);
			end else if (pick < 70) begin
				queue_frame(wrong_family(), fill, 1'b0, 16);
			end else if (pick < 80) begin
				queue_frame(FAMILY_CODE, fill, 1'b1, 16);
			end else if (pick < 85) begin
				queue_frame(wrong_family(), fill, 1'b1, 16);
			end else if (pick < 93) begin
				queue_frame($urandom_range(0, 3) == 0 ? wrong_family() : FAMILY_CODE,
					fill, 1'b0, $urandom_range(1, 15));
			end else begin
				strays = $urandom_range(1, 3);
				for (int i = 0; i < strays; i++) begin
					push_byte(8'($urandom_range(0, 255)), 1'b0);
				end
			end
		end
	endfunction

	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == MODEL_ADDR) begin
			cur_model = model_t'(data[0]);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (byte_queue.size() != 0 || fin.valid || readings_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin : run
		logic [PDATA_W-1:0] wdata;
		arst_n = 1'b0;
		fin.valid = 1'b0;
		fin.data_byte = 8'h00;
		fin.frame_start = 1'b0;
		fout.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_model = MODEL_BASE;
		byte_pos = POS_IDLE;
		crc_acc = 8'h00;
		fam_seen = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// byte at idle, full-scale frame, byte after done, cut frame, all-zero frame
		push_byte(8'h5A, 1'b0);
		queue_frame(FAMILY_CODE, FILL_ONES, 1'b0, 16);
		push_byte(8'hA5, 1'b0);
		queue_frame(FAMILY_CODE, FILL_RANDOM, 1'b0, 3);
		queue_frame(FAMILY_CODE, FILL_ZEROS, 1'b0, 16);
		queue_random(110);
		drain();

		for (int p = 1; p <= 5; p++) begin
			wdata = $urandom;
			case (p)
				1: begin
					send_idle_pct = 68;
					recv_stall_pct = 0;
					wdata[0] = MODEL_ALT;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 68;
					wdata[0] = MODEL_BASE;
				end
				3: begin
					send_idle_pct = 37;
					recv_stall_pct = 37;
					wdata[0] = MODEL_ALT;
				end
				4: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				default: begin
					send_idle_pct = 37;
					recv_stall_pct = 37;
					wdata[0] = MODEL_BASE;
				end
			endcase
			// a write to an unused address must leave the model unchanged
			reg_write(p == 4 ? SPARE_ADDR : MODEL_ADDR, wdata);
			queue_random(140);
			drain();
		end

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
